### rtl/rsqe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsqe_pkg: shared types and constants for the rotated quad expander
// Fixed-point constants of the sine/cosine approximation, register indexes
// and the particle payload record.
// ----------------------------------------------------------------------------
package rsqe_pkg;

   // Q0.32 image of 1/(2*pi); only 30 bits are nonzero.
   localparam logic [29:0] INV_TWO_PI = 30'd683565248;

   // Odd minimax polynomial coefficients in Q.24.
   localparam logic signed [31:0] POLY_C5 = -32'sd1194184960;
   localparam logic signed [31:0] POLY_C3 = 32'sd686144000;
   localparam logic signed [31:0] POLY_C1 = -32'sd105328080;

   localparam logic [24:0] Q24_ONE      = 25'h1000000;
   localparam logic [23:0] QUARTER_TURN = 24'h400000;
   localparam logic [23:0] ZERO_TURN    = 24'h000000;

   localparam int TRIG_W = 27;   // signed Q.24 sine or cosine
   localparam int OFF_W  = 33;   // signed corner offset, Q16.16

   localparam int         CSR_INDEX_W   = 8;
   localparam logic [7:0] REG_SCALE_X   = 8'd0;
   localparam logic [7:0] REG_SCALE_Y   = 8'd1;
   localparam logic [7:0] REG_LIGHT_BASE  = 8'd2;
   localparam logic [7:0] REG_LIGHT_RANGE = 8'd3;

   typedef struct packed {
      logic [63:0] position_xy;
      logic [63:0] position_zw;
      logic [63:0] size_xy;
      logic [63:0] size_zw;
      logic [47:0] colour_rgb;
      logic [15:0] alpha;
   } item_type;

endpackage

### rtl/rsqe_trig.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsqe_trig: seven-stage sine/cosine lane
// Angle to turns, triangle fold and odd polynomial, one register per product.
// ----------------------------------------------------------------------------
module rsqe_trig (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [31:0]             spin,
   input  logic signed [31:0]             age,
   input  logic [23:0]                    phase,
   output logic signed [rsqe_pkg::TRIG_W-1:0] trig_out
);
   import rsqe_pkg::*;

   logic signed [63:0] p_ff, p_in;
   logic [61:0]        a_ff, a_in;
   logic [31:0]        b_ff, b_in;
   logic signed [24:0] t3_ff, t_in, t4_ff, t5_ff, t6_ff;
   logic signed [21:0] u_ff, u_in, u5_ff;
   logic signed [53:0] m5_ff, m5_in, m6_ff, m6_in;
   logic signed [57:0] m7_ff, m7_in;

   logic [63:0]        turn_sum;
   logic [23:0]        frac;
   logic [24:0]        g, h, m;
   logic signed [49:0] tt;
   logic signed [31:0] a6;
   logic signed [32:0] b7;

   always_comb begin
      p_in = spin * age;
      a_in = {30'd0, p_ff[31:0]} * {32'd0, INV_TWO_PI};
      b_in = p_ff[63:32] * {2'b00, INV_TWO_PI};

      turn_sum = {2'b00, a_ff} + {b_ff, 32'd0};
      frac     = turn_sum[63:40] - phase;
      g        = {1'b0, frac};
      h        = Q24_ONE - g;
      m        = (g < h) ? g : h;
      t_in     = $signed(m) - 25'sd4194304;

      tt    = t3_ff * t3_ff;
      u_in  = tt[45:24];
      m5_in = u_ff * POLY_C5;
      a6    = $signed(m5_ff[53:24]) + POLY_C3;
      m6_in = u5_ff * a6;
      b7    = $signed(m6_ff[53:24]) + POLY_C1;
      m7_in = t6_ff * b7;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff  <= p_in;
         a_ff  <= a_in;
         b_ff  <= b_in;
         t3_ff <= t_in;
         u_ff  <= u_in;
         t4_ff <= t3_ff;
         m5_ff <= m5_in;
         u5_ff <= u_ff;
         t5_ff <= t4_ff;
         m6_ff <= m6_in;
         t6_ff <= t5_ff;
         m7_ff <= m7_in;
      end
   end

   assign trig_out = m7_ff[TRIG_W+23:24];

endmodule

### rtl/rotated_shaded_quad_expand.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_shaded_quad_expand: rotated, shaded billboard quad expansion
// One particle beat in, four corner beats out, the fourth marked last.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one particle per beat (valid/stall). The rsp channel
//   gives four corner beats per particle, corners 0 to 3 in order, with
//   rsp_last set on corner 3. The csr channel writes the corner scales and the
//   lighting base and range; csr_ready is always high, and writes are only
//   meant to land while no particle is in flight.
//   Corner 0 of a particle leaves after its request beat has passed the trig
//   pipeline, corner sequencer and corner pipeline; the other corners follow.
//   Throughput is bounded by the single result channel that carries one
//   corner per beat; the front trig pipeline could take one per cycle.
//   Reset clears all valid bits and loads the register defaults (scales of
//   square root of two, base of 1.0 per lane, range of 0).
//   When the receiver stalls, the corner pipeline holds in place, the corner
//   sequencer stops, and once a particle waits in the last trig stage
//   req_stall rises. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module rotated_shaded_quad_expand (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [63:0]                          req_position_xy,
   input  logic [63:0]                          req_position_zw,
   input  logic [63:0]                          req_size_xy,
   input  logic [63:0]                          req_size_zw,
   input  logic [47:0]                          req_colour_rgb,
   input  logic signed [15:0]                   req_alpha,
   input  logic signed [31:0]                   req_age_first,
   input  logic signed [31:0]                   req_age_second,
   input  logic signed [31:0]                   req_spin_rate,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_corner,
   output logic [63:0]                          rsp_vertex_xy,
   output logic [63:0]                          rsp_vertex_zw,
   output logic [31:0]                          rsp_shade_word,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rsqe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [63:0]                          csr_data
);
   import rsqe_pkg::*;

   localparam int FRONT_DEPTH = 7;
   localparam logic signed [34:0] OFF_LIM = 35'sd4294967295;

   // Saturate a widened vertex sum to the signed 32-bit range.
   function automatic logic [31:0] sat32(input logic signed [49:0] v);
      logic [31:0] r;
      if (v > 50'sd2147483647) begin
         r = 32'h7fffffff;
      end else if (v < -50'sd2147483648) begin
         r = 32'h80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Corner offset bound; legal register values never reach it.
   function automatic logic signed [OFF_W-1:0] sat_off(input logic signed [34:0] v);
      logic signed [OFF_W-1:0] r;
      if (v > OFF_LIM) begin
         r = OFF_LIM[OFF_W-1:0];
      end else if (v < -OFF_LIM) begin
         r = -OFF_LIM[OFF_W-1:0];
      end else begin
         r = v[OFF_W-1:0];
      end
      return r;
   endfunction

   // ---------------- configuration registers ----------------
   logic signed [31:0] scale_x_ff, scale_y_ff;
   logic [63:0]        light_base_ff, light_range_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff     <= 32'sd92682;
         scale_y_ff     <= 32'sd92682;
         light_base_ff  <= 64'h4000400040004000;
         light_range_ff <= 64'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SCALE_X:     scale_x_ff     <= csr_data[31:0];
            REG_SCALE_Y:     scale_y_ff     <= csr_data[31:0];
            REG_LIGHT_BASE:  light_base_ff  <= csr_data;
            REG_LIGHT_RANGE: light_range_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- front: trig pipeline, one particle per stage ----------------
   // The two trig lanes and the payload delay line move together under f_en.
   logic                     f_en;
   logic [FRONT_DEPTH-1:0]   fv_ff;
   item_type                 item_pipe_ff [FRONT_DEPTH];
   item_type                 req_item;
   logic signed [TRIG_W-1:0] sin_w, cos_w;

   assign req_item = '{position_xy: req_position_xy, position_zw: req_position_zw,
                       size_xy: req_size_xy, size_zw: req_size_zw,
                       colour_rgb: req_colour_rgb, alpha: req_alpha};

   rsqe_trig u_sin (
      .clock    (clock),
      .en       (f_en),
      .spin     (req_spin_rate),
      .age      (req_age_first),
      .phase    (QUARTER_TURN),
      .trig_out (sin_w)
   );

   rsqe_trig u_cos (
      .clock    (clock),
      .en       (f_en),
      .spin     (req_spin_rate),
      .age      (req_age_second),
      .phase    (ZERO_TURN),
      .trig_out (cos_w)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else if (f_en) begin
         fv_ff <= {fv_ff[FRONT_DEPTH-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (f_en) begin
         item_pipe_ff[0] <= req_item;
         for (int i = 1; i < FRONT_DEPTH; i++) begin
            item_pipe_ff[i] <= item_pipe_ff[i-1];
         end
      end
   end

   // ---------------- corner sequencer ----------------
   // Holds one particle and issues its four corners, one per advance of the
   // corner pipeline. It reloads in the same cycle that corner 3 leaves.
   logic                     b_en;
   logic                     x_valid_ff;
   logic [1:0]               x_cnt_ff;
   item_type                 x_item_ff;
   logic signed [OFF_W-1:0]  x_r0_ff, x_r1_ff;
   logic signed [TRIG_W-1:0] x_sn_ff, x_cs_ff;
   logic                     emit, x_free, take;
   logic signed [58:0]       rprod_x, rprod_y;

   assign emit   = x_valid_ff && b_en;
   assign x_free = !x_valid_ff || (x_cnt_ff == 2'd3 && b_en);
   assign take   = fv_ff[FRONT_DEPTH-1] && x_free;
   assign f_en   = !fv_ff[FRONT_DEPTH-1] || x_free;
   assign req_stall = !f_en;

   assign rprod_x = sin_w * scale_x_ff;
   assign rprod_y = cos_w * scale_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
         x_cnt_ff   <= 2'd0;
      end else if (take) begin
         x_valid_ff <= 1'b1;
         x_cnt_ff   <= 2'd0;
      end else if (emit) begin
         x_cnt_ff <= x_cnt_ff + 2'd1;
         if (x_cnt_ff == 2'd3) begin
            x_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         x_item_ff <= item_pipe_ff[FRONT_DEPTH-1];
         x_sn_ff   <= sin_w;
         x_cs_ff   <= cos_w;
         x_r0_ff   <= sat_off(rprod_x[58:24]);
         x_r1_ff   <= sat_off(rprod_y[58:24]);
      end
   end

   // ---------------- back: corner pipeline, five stages ----------------
   // One global advance: every stage moves unless the output is held.
   logic b1v_ff, b2v_ff, b3v_ff, b4v_ff, b5v_ff;

   assign b_en = !b5v_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         {b1v_ff, b2v_ff, b3v_ff, b4v_ff, b5v_ff} <= 5'd0;
      end else if (b_en) begin
         b1v_ff <= emit;
         b2v_ff <= b1v_ff;
         b3v_ff <= b2v_ff;
         b4v_ff <= b3v_ff;
         b5v_ff <= b4v_ff;
      end
   end

   // Stage 1: pick the offsets and trig term for this corner. The w offset
   // always equals the x offset and the z offset is zero.
   logic [1:0]               b1_k_ff;
   logic signed [OFF_W-1:0]  b1_offx_ff, b1_offy_ff, offx_in, offy_in;
   logic signed [TRIG_W-1:0] b1_trig_ff;
   item_type                 b1_item_ff;

   always_comb begin
      case (x_cnt_ff)
         2'd0: begin
            offx_in = -x_r0_ff;
            offy_in = x_r1_ff;
         end
         2'd1: begin
            offx_in = x_r1_ff;
            offy_in = x_r0_ff;
         end
         2'd2: begin
            offx_in = x_r0_ff;
            offy_in = -x_r1_ff;
         end
         default: begin
            offx_in = -x_r1_ff;
            offy_in = -x_r0_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (b_en) begin
         b1_k_ff    <= x_cnt_ff;
         b1_offx_ff <= offx_in;
         b1_offy_ff <= offy_in;
         b1_trig_ff <= x_cnt_ff[0] ? x_sn_ff : x_cs_ff;
         b1_item_ff <= x_item_ff;
      end
   end

   // Stage 2: offset times size, and lighting range times trig, per lane.
   logic [1:0]         b2_k_ff;
   logic signed [64:0] b2_px_ff, b2_py_ff, b2_pw_ff;
   logic signed [42:0] b2_rt_ff [4];
   logic [63:0]        b2_pos_xy_ff, b2_pos_zw_ff;
   logic [63:0]        b2_col_ff;

   always_ff @(posedge clock) begin
      if (b_en) begin
         b2_k_ff  <= b1_k_ff;
         b2_px_ff <= b1_offx_ff * $signed(b1_item_ff.size_xy[63:32]);
         b2_py_ff <= b1_offy_ff * $signed(b1_item_ff.size_xy[31:0]);
         b2_pw_ff <= b1_offx_ff * $signed(b1_item_ff.size_zw[31:0]);
         for (int l = 0; l < 4; l++) begin
            b2_rt_ff[l] <= $signed(light_range_ff[63-16*l -: 16]) * b1_trig_ff;
         end
         b2_pos_xy_ff <= b1_item_ff.position_xy;
         b2_pos_zw_ff <= b1_item_ff.position_zw;
         b2_col_ff    <= {b1_item_ff.colour_rgb, b1_item_ff.alpha};
      end
   end

   // Stage 3: vertex sums with saturation; shade = base plus or minus range
   // term (minus on corners 2 and 3).
   logic [1:0]         b3_k_ff;
   logic [63:0]        b3_vxy_ff, b3_vzw_ff;
   logic signed [19:0] b3_shade_ff [4];
   logic [63:0]        b3_col_ff;
   logic signed [19:0] shade_in [4];

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         if (b2_k_ff[1]) begin
            shade_in[l] = $signed(light_base_ff[63-16*l -: 16]) -
                          $signed(b2_rt_ff[l][42:24]);
         end else begin
            shade_in[l] = $signed(light_base_ff[63-16*l -: 16]) +
                          $signed(b2_rt_ff[l][42:24]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_en) begin
         b3_k_ff   <= b2_k_ff;
         b3_vxy_ff <= {sat32($signed(b2_px_ff[64:16]) + $signed(b2_pos_xy_ff[63:32])),
                       sat32($signed(b2_py_ff[64:16]) + $signed(b2_pos_xy_ff[31:0]))};
         b3_vzw_ff <= {b2_pos_zw_ff[63:32],
                       sat32($signed(b2_pw_ff[64:16]) + $signed(b2_pos_zw_ff[31:0]))};
         for (int l = 0; l < 4; l++) begin
            b3_shade_ff[l] <= shade_in[l];
         end
         b3_col_ff <= b2_col_ff;
      end
   end

   // Stage 4: colour times shade, clamped to [0, 1.0] in Q.28.
   logic [1:0]         b4_k_ff;
   logic [63:0]        b4_vxy_ff, b4_vzw_ff;
   logic [28:0]        b4_cv_ff [4];
   logic signed [35:0] cprod [4];
   logic [28:0]        cv_in [4];

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         cprod[l] = $signed(b3_col_ff[63-16*l -: 16]) * b3_shade_ff[l];
         if (cprod[l] < 36'sd0) begin
            cv_in[l] = 29'd0;
         end else if (cprod[l] > 36'sd268435456) begin
            cv_in[l] = 29'h10000000;
         end else begin
            cv_in[l] = cprod[l][28:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_en) begin
         b4_k_ff   <= b3_k_ff;
         b4_vxy_ff <= b3_vxy_ff;
         b4_vzw_ff <= b3_vzw_ff;
         for (int l = 0; l < 4; l++) begin
            b4_cv_ff[l] <= cv_in[l];
         end
      end
   end

   // Stage 5: scale to 0..255, truncate and pack RGBA into the output beat.
   logic [1:0]  b5_k_ff;
   logic [63:0] b5_vxy_ff, b5_vzw_ff;
   logic [31:0] b5_shade_ff, shade_word_in;
   logic [36:0] bprod [4];

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         bprod[l] = {8'd0, b4_cv_ff[l]} * 37'd255;
         shade_word_in[31-8*l -: 8] = bprod[l][35:28];
      end
   end

   always_ff @(posedge clock) begin
      if (b_en) begin
         b5_k_ff     <= b4_k_ff;
         b5_vxy_ff   <= b4_vxy_ff;
         b5_vzw_ff   <= b4_vzw_ff;
         b5_shade_ff <= shade_word_in;
      end
   end

   assign rsp_valid      = b5v_ff;
   assign rsp_corner     = b5_k_ff;
   assign rsp_vertex_xy  = b5_vxy_ff;
   assign rsp_vertex_zw  = b5_vzw_ff;
   assign rsp_shade_word = b5_shade_ff;
   assign rsp_last       = (b5_k_ff == 2'd3);

endmodule
